// ===== src/mclpp_pkg.sv =====
// ----------------------------------------------------------------------------
// mclpp_pkg: shared types and constants of the motor current limiter
// Holds the widths, reset values, register indexes, result kinds and the
// command and status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package mclpp_pkg;

    // field widths
    localparam int SAMPLE_W    = 14;
    localparam int CURRENT_W   = 23;
    localparam int PERIOD_W    = 16;
    localparam int MAX_CUR_W   = 20;
    localparam int SCALE_W     = 17;
    localparam int GAIN_W      = 16;
    localparam int COUNT_W     = 11;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    // internal arithmetic widths
    localparam int LIM_W   = 20;   // current limit
    localparam int DEN_W   = 21;   // limit plus one
    localparam int ERR_W   = 24;   // current minus limit
    localparam int Q_W     = 41;   // scaled numerator factor, signed
    localparam int QMAG_W  = 40;   // its magnitude
    localparam int QHALF_W = 20;   // half of the magnitude for the split multiply
    localparam int BASE_W  = 18;   // period minus dead time, signed
    localparam int BMAG_W  = 16;   // its magnitude
    localparam int PROD_W  = 36;   // one partial product
    localparam int NUM_W   = 48;   // numerator magnitude after the divide by 256
    localparam int QUO_W   = 16;   // quotient bits found by the divider
    localparam int TGT_W   = 20;   // signed period target before clamping

    // division steps
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // default parameter values
    localparam int CAL_INTERVAL_DEF = 1000;
    localparam int PRE_OFF_DEF      = 16;
    localparam int POST_OFF_DEF     = 16;
    localparam int MIN_PERIOD_DEF   = 128;

    // thresholds and reset values
    localparam logic [SAMPLE_W-1:0]  POWERED_MIN     = 14'd2048;   // 0.5 V
    localparam logic [SAMPLE_W-1:0]  OFFSET_RESET    = 14'd6758;   // 1.65 V
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET    = 16'hffff;
    localparam logic [MAX_CUR_W-1:0] MAX_CUR_RESET   = 20'd2048;
    localparam logic [SCALE_W-1:0]   SCALE_RESET     = 17'd65536;
    localparam logic [SCALE_W-1:0]   SCALE_ONE       = 17'd65536;
    localparam logic [GAIN_W-1:0]    GAIN_P_RESET    = 16'd384;
    localparam logic [GAIN_W-1:0]    SENSE_G_RESET   = 16'd2560;
    localparam logic [PERIOD_W-1:0]  MAX_PER_RESET   = 16'hffff;
    localparam logic [COUNT_W-1:0]   COUNT_MAX       = 11'd2047;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_SCALE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSE_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PERIOD    = 3'd4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CONTROL   = 2'd0,
        KIND_CAL_START = 2'd1,
        KIND_OFFSET    = 2'd2,
        KIND_DISCARD   = 2'd3
    } kind_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CURRENT,
        OP_OFFSET,
        OP_PRODUCT,
        OP_QSUM,
        OP_ABS,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;      // load the output register
        kind_t  kind;
        logic   cal_pin;
    } dp_cmd_t;

    typedef struct packed {
        logic powered;     // held sample is at least 0.5 V
    } dp_status_t;

endpackage

// ===== src/mclpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mclpp_ctrl: sequencing controller of the current limiter
// Steps the datapath through one item, keeps the calibration bookkeeping and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module mclpp_ctrl #(
    parameter int CAL_INTERVAL = mclpp_pkg::CAL_INTERVAL_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  mclpp_pkg::dp_status_t  status,
    output mclpp_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CURRENT,
        ST_DECIDE,
        ST_PRODUCT,
        ST_QSUM,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH,
        ST_EMIT
    } state_t;

    localparam logic [mclpp_pkg::COUNT_W-1:0] CAL_LIMIT =
        mclpp_pkg::COUNT_W'(CAL_INTERVAL);
    localparam logic [mclpp_pkg::DIV_CNT_W-1:0] DIV_LAST =
        mclpp_pkg::DIV_CNT_W'(mclpp_pkg::DIV_STEPS - 1);

    state_t                              state_reg, state_next;
    logic [mclpp_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic                                cal_reg, cal_next;
    logic                                discard_reg, discard_next;
    mclpp_pkg::kind_t                    kind_reg, kind_next;
    logic [mclpp_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                fall_through;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cal_next       = cal_reg;
        discard_next   = discard_reg;
        kind_next      = kind_reg;
        div_cnt_next   = div_cnt_reg;
        fall_through   = 1'b0;
        cmd.op         = mclpp_pkg::OP_NONE;
        cmd.emit       = 1'b0;
        cmd.kind       = kind_reg;
        cmd.cal_pin    = cal_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = mclpp_pkg::OP_LOAD;
                    state_next = ST_CURRENT;
                end
            end
            ST_CURRENT:
            begin
                cmd.op     = mclpp_pkg::OP_CURRENT;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.powered && !cal_reg && (count_reg > CAL_LIMIT))
                begin
                    // start of an offset calibration
                    cal_next   = 1'b1;
                    count_next = '0;
                    kind_next  = mclpp_pkg::KIND_CAL_START;
                    state_next = ST_EMIT;
                end
                else if (status.powered && cal_reg)
                begin
                    // this sample is the new zero-current reference
                    cmd.op       = mclpp_pkg::OP_OFFSET;
                    cal_next     = 1'b0;
                    discard_next = 1'b1;
                    kind_next    = mclpp_pkg::KIND_OFFSET;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    fall_through = 1'b1;
                    if (status.powered && (count_reg != mclpp_pkg::COUNT_MAX))
                    begin
                        count_next = count_reg + mclpp_pkg::COUNT_W'(1);
                    end
                end

                if (fall_through)
                begin
                    if (discard_reg)
                    begin
                        discard_next = 1'b0;
                        kind_next    = mclpp_pkg::KIND_DISCARD;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        kind_next  = mclpp_pkg::KIND_CONTROL;
                        state_next = ST_PRODUCT;
                    end
                end
            end
            ST_PRODUCT:
            begin
                cmd.op     = mclpp_pkg::OP_PRODUCT;
                state_next = ST_QSUM;
            end
            ST_QSUM:
            begin
                cmd.op     = mclpp_pkg::OP_QSUM;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.op     = mclpp_pkg::OP_ABS;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.op     = mclpp_pkg::OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.op     = mclpp_pkg::OP_MUL_HI;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = mclpp_pkg::OP_SUM;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.op       = mclpp_pkg::OP_DIV_INIT;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op       = mclpp_pkg::OP_DIV_STEP;
                div_cnt_next = div_cnt_reg + mclpp_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.op     = mclpp_pkg::OP_FINISH;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cal_reg       <= 1'b0;
            discard_reg   <= 1'b0;
            kind_reg      <= mclpp_pkg::KIND_CONTROL;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cal_reg       <= cal_next;
            discard_reg   <= discard_next;
            kind_reg      <= kind_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/mclpp_datapath.sv =====
// ----------------------------------------------------------------------------
// mclpp_datapath: arithmetic and storage of the current limiter
// Holds the configuration registers, offset and period, converts the sample
// to a current and runs the period rule through a split multiply and a
// restoring divider, one step per command.
// ----------------------------------------------------------------------------
module mclpp_datapath #(
    parameter int PRE_OFF    = mclpp_pkg::PRE_OFF_DEF,
    parameter int POST_OFF   = mclpp_pkg::POST_OFF_DEF,
    parameter int MIN_PERIOD = mclpp_pkg::MIN_PERIOD_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mclpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mclpp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [mclpp_pkg::SAMPLE_W-1:0]       sample_voltage,
    input  mclpp_pkg::dp_cmd_t                   cmd,
    output mclpp_pkg::dp_status_t                status,
    output logic [1:0]                           kind,
    output logic signed [mclpp_pkg::CURRENT_W-1:0] current,
    output logic [mclpp_pkg::PERIOD_W-1:0]       period,
    output logic                                 cal_pin
);

    localparam int TGT_W = mclpp_pkg::TGT_W;
    localparam logic [mclpp_pkg::BASE_W-1:0] OFF_SUM =
        mclpp_pkg::BASE_W'(PRE_OFF + POST_OFF);
    localparam logic signed [TGT_W-1:0] OFF_SUM_T = TGT_W'(PRE_OFF + POST_OFF);
    localparam logic signed [TGT_W-1:0] MIN_T     = TGT_W'(MIN_PERIOD);
    localparam logic [mclpp_pkg::PERIOD_W-1:0] MIN_P =
        mclpp_pkg::PERIOD_W'(MIN_PERIOD);

    // configuration
    logic [mclpp_pkg::MAX_CUR_W-1:0] current_limit_reg;
    logic [mclpp_pkg::SCALE_W-1:0]   power_scale_reg;
    logic [mclpp_pkg::GAIN_W-1:0]    gain_p_reg;
    logic [mclpp_pkg::GAIN_W-1:0]    sense_gain_reg;
    logic [mclpp_pkg::PERIOD_W-1:0]  max_period_reg;
    logic [mclpp_pkg::SCALE_W-1:0]   scale_in;

    // block state
    logic [mclpp_pkg::SAMPLE_W-1:0]  offset_reg;
    logic [mclpp_pkg::PERIOD_W-1:0]  pwm_period_reg, pwm_period_next;

    // working registers
    logic [mclpp_pkg::SAMPLE_W-1:0]          sample_reg;
    logic signed [mclpp_pkg::CURRENT_W-1:0]  cur_reg, cur_next;
    logic [mclpp_pkg::LIM_W-1:0]             lim_reg;
    logic signed [mclpp_pkg::Q_W-1:0]        e_reg;
    logic signed [mclpp_pkg::BASE_W-1:0]     base_reg;
    logic signed [mclpp_pkg::Q_W-1:0]        q_reg;
    logic [mclpp_pkg::QMAG_W-1:0]            qmag_reg;
    logic [mclpp_pkg::BMAG_W-1:0]            bmag_reg;
    logic                                    neg_reg;
    logic [mclpp_pkg::PROD_W-1:0]            plo_reg, phi_reg;
    logic [mclpp_pkg::NUM_W-1:0]             num_reg;
    logic                                    ovf_reg;
    logic [mclpp_pkg::DEN_W-1:0]             rem_reg;
    logic [mclpp_pkg::QUO_W-1:0]             dvd_reg;

    // output register payload
    logic [1:0]                              kind_reg;
    logic signed [mclpp_pkg::CURRENT_W-1:0]  current_reg;
    logic [mclpp_pkg::PERIOD_W-1:0]          period_reg;
    logic                                    cal_pin_reg;

    // combinational helpers
    logic signed [mclpp_pkg::SAMPLE_W:0]     diff_s;
    logic signed [mclpp_pkg::GAIN_W:0]       sense_s;
    logic signed [31:0]                      cur_prod;
    logic signed [32:0]                      cur_bias;
    logic signed [24:0]                      cur_wide;
    logic [35:0]                             lim_prod;
    logic signed [mclpp_pkg::ERR_W-1:0]      err_s;
    logic signed [mclpp_pkg::GAIN_W:0]       gain_s;
    logic signed [mclpp_pkg::Q_W-1:0]        e_prod;
    logic [mclpp_pkg::DEN_W-1:0]             den;
    logic signed [mclpp_pkg::Q_W-1:0]        q_abs;
    logic signed [mclpp_pkg::BASE_W-1:0]     base_abs;
    logic [55:0]                             num_sum;
    logic [mclpp_pkg::DEN_W:0]               trial;
    logic [mclpp_pkg::DEN_W:0]               trial_diff;
    logic [mclpp_pkg::QUO_W:0]               quo_mag;
    logic signed [mclpp_pkg::QUO_W+1:0]      quo_s;
    logic signed [TGT_W-1:0]                 target;
    logic signed [TGT_W-1:0]                 max_t;

    assign scale_in = cfg_data[mclpp_pkg::SCALE_W-1:0];

    // current = trunc((offset - sample) * sense_gain / 256), zero when unpowered
    always_comb
    begin
        diff_s   = $signed({1'b0, offset_reg}) - $signed({1'b0, sample_reg});
        sense_s  = $signed({1'b0, sense_gain_reg});
        cur_prod = diff_s * sense_s;
        cur_bias = cur_prod[31] ? (33'(cur_prod) + 33'sd255) : 33'(cur_prod);
        cur_wide = 25'(cur_bias >>> 8);
        if (!status.powered)
        begin
            cur_next = '0;
        end
        else if (cur_wide > 25'sd4194303)
        begin
            cur_next = 23'sh3fffff;
        end
        else if (cur_wide < -25'sd4194304)
        begin
            cur_next = 23'sh400000;
        end
        else
        begin
            cur_next = cur_wide[mclpp_pkg::CURRENT_W-1:0];
        end
        lim_prod = 36'(current_limit_reg) * 36'(power_scale_reg);
    end

    // error times gain, numerator factor and magnitudes
    always_comb
    begin
        err_s    = $signed({cur_reg[mclpp_pkg::CURRENT_W-1], cur_reg})
                   - $signed({4'b0, lim_reg});
        gain_s   = $signed({1'b0, gain_p_reg});
        e_prod   = err_s * gain_s;
        den      = {1'b0, lim_reg} + mclpp_pkg::DEN_W'(1);
        q_abs    = q_reg[mclpp_pkg::Q_W-1] ? -q_reg : q_reg;
        base_abs = base_reg[mclpp_pkg::BASE_W-1] ? -base_reg : base_reg;
        num_sum  = 56'(plo_reg) + {phi_reg, 20'b0};
    end

    // one restoring step and the final clamp
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[mclpp_pkg::QUO_W-1]};
        trial_diff = trial - {1'b0, den};
        quo_mag    = ovf_reg ? {1'b1, {mclpp_pkg::QUO_W{1'b0}}} : {1'b0, dvd_reg};
        quo_s      = neg_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
        target     = TGT_W'(quo_s) + OFF_SUM_T;
        max_t      = $signed({4'b0, max_period_reg});
        if (target > max_t)
        begin
            target = max_t;
        end
        if (target < MIN_T)
        begin
            pwm_period_next = MIN_P;
        end
        else
        begin
            pwm_period_next = target[mclpp_pkg::PERIOD_W-1:0];
        end
    end

    assign status.powered = (sample_reg >= mclpp_pkg::POWERED_MIN);

    // configuration and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_limit_reg <= mclpp_pkg::MAX_CUR_RESET;
            power_scale_reg   <= mclpp_pkg::SCALE_RESET;
            gain_p_reg        <= mclpp_pkg::GAIN_P_RESET;
            sense_gain_reg    <= mclpp_pkg::SENSE_G_RESET;
            max_period_reg    <= mclpp_pkg::MAX_PER_RESET;
            offset_reg        <= mclpp_pkg::OFFSET_RESET;
            pwm_period_reg    <= mclpp_pkg::PERIOD_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mclpp_pkg::CFG_CURRENT_LIMIT:
                        current_limit_reg <= cfg_data;
                    mclpp_pkg::CFG_POWER_SCALE:
                        power_scale_reg <= (scale_in > mclpp_pkg::SCALE_ONE)
                                           ? mclpp_pkg::SCALE_ONE : scale_in;
                    mclpp_pkg::CFG_GAIN_P:
                        gain_p_reg <= cfg_data[mclpp_pkg::GAIN_W-1:0];
                    mclpp_pkg::CFG_SENSE_GAIN:
                        sense_gain_reg <= cfg_data[mclpp_pkg::GAIN_W-1:0];
                    mclpp_pkg::CFG_MAX_PERIOD:
                        max_period_reg <= cfg_data[mclpp_pkg::PERIOD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == mclpp_pkg::OP_OFFSET)
            begin
                offset_reg <= sample_reg;
            end
            if (cmd.op == mclpp_pkg::OP_FINISH)
            begin
                pwm_period_reg <= pwm_period_next;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mclpp_pkg::OP_LOAD:
                sample_reg <= sample_voltage;
            mclpp_pkg::OP_CURRENT:
            begin
                cur_reg <= cur_next;
                lim_reg <= lim_prod[35:16];
            end
            mclpp_pkg::OP_PRODUCT:
            begin
                e_reg    <= e_prod;
                base_reg <= $signed({2'b0, pwm_period_reg}) - $signed(OFF_SUM);
            end
            mclpp_pkg::OP_QSUM:
                q_reg <= e_reg + $signed({12'b0, den, 8'b0});
            mclpp_pkg::OP_ABS:
            begin
                qmag_reg <= q_abs[mclpp_pkg::QMAG_W-1:0];
                bmag_reg <= base_abs[mclpp_pkg::BMAG_W-1:0];
                neg_reg  <= q_reg[mclpp_pkg::Q_W-1] ^ base_reg[mclpp_pkg::BASE_W-1];
            end
            mclpp_pkg::OP_MUL_LO:
                plo_reg <= 36'(bmag_reg) * 36'(qmag_reg[mclpp_pkg::QHALF_W-1:0]);
            mclpp_pkg::OP_MUL_HI:
                phi_reg <= 36'(bmag_reg)
                           * 36'(qmag_reg[mclpp_pkg::QMAG_W-1:mclpp_pkg::QHALF_W]);
            mclpp_pkg::OP_SUM:
                num_reg <= num_sum[55:8];
            mclpp_pkg::OP_DIV_INIT:
            begin
                ovf_reg <= (num_reg >= {11'b0, den, 16'b0});
                rem_reg <= num_reg[mclpp_pkg::DEN_W+15:16];
                dvd_reg <= num_reg[15:0];
            end
            mclpp_pkg::OP_DIV_STEP:
            begin
                if (!trial_diff[mclpp_pkg::DEN_W])
                begin
                    rem_reg <= trial_diff[mclpp_pkg::DEN_W-1:0];
                    dvd_reg <= {dvd_reg[mclpp_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[mclpp_pkg::DEN_W-1:0];
                    dvd_reg <= {dvd_reg[mclpp_pkg::QUO_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.emit)
        begin
            kind_reg    <= cmd.kind;
            current_reg <= cur_reg;
            period_reg  <= pwm_period_reg;
            cal_pin_reg <= cmd.cal_pin;
        end
    end

    assign kind    = kind_reg;
    assign current = current_reg;
    assign period  = period_reg;
    assign cal_pin = cal_pin_reg;

endmodule

// ===== src/motor_current_limit_pwm_period_unit.sv =====
// ----------------------------------------------------------------------------
// motor_current_limit_pwm_period_unit: current limiter for the PWM period
// Turns each current-sense sample into a current, handles the periodic
// offset calibration and scales the PWM period by a proportional rule.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ----------------------------------
//  input     in         in_valid / in_stall   sample_voltage
//  output    out        out_valid / out_stall kind, current, period, cal_pin
//  config    in         cfg_write             cfg_index, cfg_data
//
//  calibration, offset and discard items pass from acceptance through the
//  current and decide states to the emit state; a control update also runs
//  the product, split multiply, 16-step restoring divider and finish states
//  one item is worked on at a time; the next is taken the cycle after the
//  previous result has moved into the output register, which may still be
//  stalled, so an item holds the input from acceptance until it is emitted
//  reset clears the sequencer, the calibration count and flags, loads the
//  register defaults, a 1.65 V offset and the full-scale period
//  a stalled output holds its item and the block waits before writing another
//
module motor_current_limit_pwm_period_unit #(
    parameter int CAL_INTERVAL = mclpp_pkg::CAL_INTERVAL_DEF,
    parameter int PRE_OFF      = mclpp_pkg::PRE_OFF_DEF,
    parameter int POST_OFF     = mclpp_pkg::POST_OFF_DEF,
    parameter int MIN_PERIOD   = mclpp_pkg::MIN_PERIOD_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_write,
    input  logic [mclpp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mclpp_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [mclpp_pkg::SAMPLE_W-1:0]         sample_voltage,
    // result output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             kind,
    output logic signed [mclpp_pkg::CURRENT_W-1:0] current,
    output logic [mclpp_pkg::PERIOD_W-1:0]         period,
    output logic                                   cal_pin
);

    // command and status between sequencer and arithmetic
    mclpp_pkg::dp_cmd_t    cmd;
    mclpp_pkg::dp_status_t status;

    // sequencer: item handshakes, calibration count and flags, step order
    mclpp_ctrl #(
        .CAL_INTERVAL (CAL_INTERVAL)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic: registers, offset, period, multiplier and divider steps
    mclpp_datapath #(
        .PRE_OFF    (PRE_OFF),
        .POST_OFF   (POST_OFF),
        .MIN_PERIOD (MIN_PERIOD)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_voltage (sample_voltage),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .current        (current),
        .period         (period),
        .cal_pin        (cal_pin)
    );

endmodule
